// ----- src/spb_pkg.sv -----
// Package: shared types, constants and codes of the sprite blit pipeline.
`default_nettype none
package spb_pkg;

    localparam int PART_ROWS       = 256;
    localparam int ROW_BYTES       = 256;
    localparam int PALETTE_ENTRIES = 256;
    localparam int SURFACE_WIDTH   = 640;
    localparam int SURFACE_HEIGHT  = 480;

    localparam int PART_DEPTH = PART_ROWS * ROW_BYTES;
    localparam int PART_AW    = $clog2(PART_DEPTH);
    localparam int PAL_AW     = $clog2(PALETTE_ENTRIES);

    localparam int FULL_SCALE  = 1000;
    localparam int SCALE_SHIFT = 28;
    localparam int SCALE_RECIP = ((1 << SCALE_SHIFT) + FULL_SCALE - 1) / FULL_SCALE;
    localparam int RECIP_W     = $clog2(SCALE_RECIP + 1);
    localparam int PROD_W      = 18;
    localparam int QPROD_W     = PROD_W + RECIP_W;

    localparam int Q_W   = 12;
    localparam int REM_W = 23;

    localparam logic [3:0] NIBBLE_MASK = 4'h f;

    typedef enum logic [1:0] {
        OP_LOAD_PART = 2'd0,
        OP_LOAD_PAL  = 2'd1,
        OP_DRAW      = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        DEPTH_1BPP = 2'd0,
        DEPTH_4BPP = 2'd1,
        DEPTH_8BPP = 2'd2
    } t_depth;

    typedef enum logic [2:0] {
        REG_PART_WIDTH  = 3'd0,
        REG_PART_HEIGHT = 3'd1,
        REG_DEPTH_MODE  = 3'd2,
        REG_DEST_WIDTH  = 3'd3,
        REG_DEST_HEIGHT = 3'd4,
        REG_ORIGIN_X    = 3'd5,
        REG_ORIGIN_Y    = 3'd6,
        REG_BRIGHTNESS  = 3'd7
    } t_reg_idx;

    typedef struct packed {
        t_op         operation;
        logic [7:0]  load_row;
        logic [7:0]  load_column;
        logic [7:0]  load_byte;
        logic [7:0]  palette_slot;
        logic [7:0]  palette_red;
        logic [7:0]  palette_green;
        logic [7:0]  palette_blue;
        logic [10:0] local_x;
        logic [10:0] local_y;
        logic [7:0]  palette_shift;
    } t_in;

    typedef struct packed {
        logic        write_enable;
        logic [9:0]  surf_x;
        logic [9:0]  surf_y;
        logic [7:0]  out_red;
        logic [7:0]  out_green;
        logic [7:0]  out_blue;
    } t_out;

    typedef struct packed {
        logic [11:0]        part_width;
        logic [8:0]         part_height;
        logic [1:0]         depth_mode;
        logic [10:0]        dest_width;
        logic [10:0]        dest_height;
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic [9:0]         brightness;
    } t_cfg;

    typedef struct packed {
        t_in              item;
        logic             ok;
        logic [9:0]       tx;
        logic [9:0]       ty;
        logic [REM_W-1:0] rem_x;
        logic [REM_W-1:0] rem_y;
        logic [Q_W-1:0]   q_x;
        logic [Q_W-1:0]   q_y;
    } t_map;

    typedef struct packed {
        t_in        item;
        logic       ok;
        logic [9:0] tx;
        logic [9:0] ty;
        logic [2:0] sx_lo;
    } t_fetch;

    typedef struct packed {
        logic        ok;
        logic [9:0]  tx;
        logic [9:0]  ty;
        logic [23:0] rgb;
    } t_px;

    typedef struct packed {
        logic                  ok;
        logic [9:0]            tx;
        logic [9:0]            ty;
        logic [2:0][PROD_W-1:0] prod;
    } t_sh1;

    typedef struct packed {
        logic                   ok;
        logic [9:0]             tx;
        logic [9:0]             ty;
        logic [2:0][QPROD_W-1:0] qprod;
    } t_sh2;

endpackage
`default_nettype wire

// ----- src/scaled_palette_sprite_blit.sv -----
// Top level: configuration registers and the sprite blit pipeline.
// Every transaction on the input channel (part byte load, palette load or draw pixel)
// yields exactly one result, in order; one transaction is taken per clock unless a
// stalled output has filled the pipeline. The path runs through the 12-stage
// restoring divider that maps destination pixels to source pixels, followed by the
// registered part store and palette reads and two multiply stages of brightness
// scaling. Loads take effect for every later draw. Stalls collapse bubbles, so the
// input keeps accepting while a result waits. Results with write_enable low carry zeros.
// Configuration writes are accepted every cycle and must be issued while idle.
`default_nettype none
module scaled_palette_sprite_blit import spb_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in        i_in_data,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out            o_out_data,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    t_cfg r_cfg;
    logic map_valid;
    logic map_ready;
    t_map map_item;
    logic px_valid;
    logic px_ready;
    t_px  px_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.part_width  <= 12'd1;
            r_cfg.part_height <= 9'd1;
            r_cfg.depth_mode  <= DEPTH_8BPP;
            r_cfg.dest_width  <= '0;
            r_cfg.dest_height <= '0;
            r_cfg.origin_x    <= '0;
            r_cfg.origin_y    <= '0;
            r_cfg.brightness  <= 10'(FULL_SCALE);
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_PART_WIDTH:  r_cfg.part_width  <= i_cfg_data[11:0];
                REG_PART_HEIGHT: r_cfg.part_height <= i_cfg_data[8:0];
                REG_DEPTH_MODE:  r_cfg.depth_mode  <= i_cfg_data[1:0];
                REG_DEST_WIDTH:  r_cfg.dest_width  <= i_cfg_data[10:0];
                REG_DEST_HEIGHT: r_cfg.dest_height <= i_cfg_data[10:0];
                REG_ORIGIN_X:    r_cfg.origin_x    <= $signed(i_cfg_data);
                REG_ORIGIN_Y:    r_cfg.origin_y    <= $signed(i_cfg_data);
                REG_BRIGHTNESS:  r_cfg.brightness  <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    spb_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .i_item  (i_in_data),
        .o_ready (o_in_ready),
        .o_valid (map_valid),
        .o_item  (map_item),
        .i_ready (map_ready)
    );

    spb_fetch u_fetch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (map_valid),
        .i_item  (map_item),
        .o_ready (map_ready),
        .o_valid (px_valid),
        .o_item  (px_item),
        .i_ready (px_ready)
    );

    spb_shade u_shade (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (px_valid),
        .i_item  (px_item),
        .o_ready (px_ready),
        .o_valid (o_out_valid),
        .o_item  (o_out_data),
        .i_ready (i_out_ready)
    );

    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.write_enable |-> o_out_data == '0)
        else $error("result without write carries nonzero fields");

    a_x_on_surface: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.write_enable |-> 32'(o_out_data.surf_x) < SURFACE_WIDTH)
        else $error("written column off surface");

    a_y_on_surface: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.write_enable |-> 32'(o_out_data.surf_y) < SURFACE_HEIGHT)
        else $error("written row off surface");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule
`default_nettype wire

// ----- src/spb_map.sv -----
// Destination-to-source mapping: rectangle and surface checks, scale multiply, divider pipeline.
`default_nettype none
module spb_map import spb_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_valid,
    input  wire t_in  i_item,
    output logic      o_ready,
    output logic      o_valid,
    output t_map      o_item,
    input  wire logic i_ready
);

    localparam int NST = Q_W + 1;

    logic [NST-1:0] r_v;
    logic [NST-1:0] rdy;
    t_map           r_d [NST];
    t_map           n_d [NST];

    logic signed [16:0] tx_s;
    logic signed [16:0] ty_s;
    logic               in_rect;
    logic               on_surf;

    always_comb begin
        rdy[NST-1] = !r_v[NST-1] || i_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    always_comb begin
        tx_s = {i_cfg.origin_x[15], i_cfg.origin_x} + $signed({6'b0, i_item.local_x});
        ty_s = {i_cfg.origin_y[15], i_cfg.origin_y} + $signed({6'b0, i_item.local_y});
        in_rect = (i_cfg.dest_width != '0) && (i_cfg.dest_height != '0)
               && (i_cfg.part_width != '0) && (i_cfg.part_height != '0)
               && (i_item.local_x < i_cfg.dest_width)
               && (i_item.local_y < i_cfg.dest_height);
        on_surf = !tx_s[16] && (tx_s < 17'(SURFACE_WIDTH))
               && !ty_s[16] && (ty_s < 17'(SURFACE_HEIGHT));
        n_d[0].item  = i_item;
        n_d[0].ok    = (i_item.operation == OP_DRAW) && in_rect && on_surf;
        n_d[0].tx    = tx_s[9:0];
        n_d[0].ty    = ty_s[9:0];
        n_d[0].rem_x = REM_W'(i_item.local_x) * REM_W'(i_cfg.part_width);
        n_d[0].rem_y = REM_W'(i_item.local_y) * REM_W'(i_cfg.part_height);
        n_d[0].q_x   = '0;
        n_d[0].q_y   = '0;
        for (int k = 1; k < NST; k++) begin
            logic [REM_W-1:0] dvx;
            logic [REM_W-1:0] dvy;
            dvx = REM_W'(i_cfg.dest_width) << (NST - 1 - k);
            dvy = REM_W'(i_cfg.dest_height) << (NST - 1 - k);
            n_d[k] = r_d[k-1];
            if (r_d[k-1].rem_x >= dvx) begin
                n_d[k].rem_x = r_d[k-1].rem_x - dvx;
                n_d[k].q_x[NST-1-k] = 1'b1;
            end
            if (r_d[k-1].rem_y >= dvy) begin
                n_d[k].rem_y = r_d[k-1].rem_y - dvy;
                n_d[k].q_y[NST-1-k] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NST; k++) begin
            if (rdy[k]) begin
                r_d[k] <= n_d[k];
            end
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_v[NST-1];
    assign o_item  = r_d[NST-1];

endmodule
`default_nettype wire

// ----- src/spb_fetch.sv -----
// Part store and palette: byte fetch, pixel unpack, transparency, palette lookup.
`default_nettype none
module spb_fetch import spb_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_valid,
    input  wire t_map i_item,
    output logic      o_ready,
    output logic      o_valid,
    output t_px       o_item,
    input  wire logic i_ready
);

    logic [7:0]  r_part [PART_DEPTH];
    logic [23:0] r_pal  [PALETTE_ENTRIES];

    logic        r_v1;
    logic        r_v2;
    t_fetch      r_d1;
    t_fetch      n_d1;
    logic [7:0]  r_byte;
    logic        r_ok2;
    logic [9:0]  r_tx2;
    logic [9:0]  r_ty2;
    logic [23:0] r_rgb;
    logic        rdy1;
    logic        rdy2;

    logic [8:0]         row;
    logic [11:0]        col;
    logic               src_in;
    logic [PART_AW-1:0] raddr;
    logic               ld_in;
    logic [PART_AW-1:0] waddr;
    logic [7:0]         idx;
    logic               low_depth;
    logic [7:0]         pidx;
    logic               ok2;

    assign rdy2    = !r_v2 || i_ready;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    always_comb begin
        row = i_cfg.part_height - 9'd1 - i_item.q_y[8:0];
        unique case (t_depth'(i_cfg.depth_mode))
            DEPTH_1BPP: col = i_item.q_x >> 3;
            DEPTH_4BPP: col = i_item.q_x >> 1;
            default:    col = i_item.q_x;
        endcase
        src_in = (32'(row) < 32'(PART_ROWS)) && (32'(col) < 32'(ROW_BYTES));
        raddr  = PART_AW'(32'(row) * 32'(ROW_BYTES) + 32'(col));
        ld_in  = (32'(i_item.item.load_row) < 32'(PART_ROWS))
              && (32'(i_item.item.load_column) < 32'(ROW_BYTES));
        waddr  = PART_AW'(32'(i_item.item.load_row) * 32'(ROW_BYTES)
                          + 32'(i_item.item.load_column));
        n_d1.item  = i_item.item;
        n_d1.ok    = i_item.ok && src_in;
        n_d1.tx    = i_item.tx;
        n_d1.ty    = i_item.ty;
        n_d1.sx_lo = i_item.q_x[2:0];
    end

    always_comb begin
        unique case (t_depth'(i_cfg.depth_mode))
            DEPTH_1BPP: begin
                idx = {7'b0, r_byte[3'd7 - r_d1.sx_lo]};
                low_depth = 1'b1;
            end
            DEPTH_4BPP: begin
                idx = {4'b0, (r_d1.sx_lo[0] ? r_byte[3:0] : r_byte[7:4]) & NIBBLE_MASK};
                low_depth = 1'b1;
            end
            default: begin
                idx = r_byte;
                low_depth = 1'b0;
            end
        endcase
        ok2  = r_d1.ok && !(low_depth && idx == 8'd0);
        pidx = idx + r_d1.item.palette_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            if (i_item.item.operation == OP_LOAD_PART && ld_in) begin
                r_part[waddr] <= i_item.item.load_byte;
            end
            r_byte <= r_part[raddr];
        end
        if (rdy1) begin
            r_d1 <= n_d1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) begin
            if (r_d1.item.operation == OP_LOAD_PAL) begin
                r_pal[PAL_AW'(r_d1.item.palette_slot)] <= {r_d1.item.palette_red,
                    r_d1.item.palette_green, r_d1.item.palette_blue};
            end
            r_rgb <= r_pal[PAL_AW'(pidx)];
        end
        if (rdy2) begin
            r_ok2 <= ok2;
            r_tx2 <= r_d1.tx;
            r_ty2 <= r_d1.ty;
        end
    end

    assign o_valid = r_v2;
    assign o_item  = '{ok: r_ok2, tx: r_tx2, ty: r_ty2, rgb: r_rgb};

endmodule
`default_nettype wire

// ----- src/spb_shade.sv -----
// Brightness scaling of the palette color and the result register.
`default_nettype none
module spb_shade import spb_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_valid,
    input  wire t_px  i_item,
    output logic      o_ready,
    output logic      o_valid,
    output t_out      o_item,
    input  wire logic i_ready
);

    logic   r_v1;
    logic   r_v2;
    logic   r_v3;
    t_sh1   r_d1;
    t_sh1   n_d1;
    t_sh2   r_d2;
    t_sh2   n_d2;
    t_out   r_out;
    t_out   n_out;
    logic   rdy1;
    logic   rdy2;
    logic   rdy3;
    logic [9:0] bsat;

    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    always_comb begin
        bsat = (i_cfg.brightness > 10'(FULL_SCALE)) ? 10'(FULL_SCALE) : i_cfg.brightness;
        n_d1.ok = i_item.ok;
        n_d1.tx = i_item.tx;
        n_d1.ty = i_item.ty;
        for (int c = 0; c < 3; c++) begin
            n_d1.prod[c] = PROD_W'(i_item.rgb[c*8 +: 8]) * PROD_W'(bsat);
        end
        n_d2.ok = r_d1.ok;
        n_d2.tx = r_d1.tx;
        n_d2.ty = r_d1.ty;
        for (int c = 0; c < 3; c++) begin
            n_d2.qprod[c] = QPROD_W'(r_d1.prod[c]) * QPROD_W'(SCALE_RECIP);
        end
        n_out = '0;
        if (r_d2.ok) begin
            n_out.write_enable = 1'b1;
            n_out.surf_x       = r_d2.tx;
            n_out.surf_y       = r_d2.ty;
            n_out.out_blue     = 8'(r_d2.qprod[0] >> SCALE_SHIFT);
            n_out.out_green    = 8'(r_d2.qprod[1] >> SCALE_SHIFT);
            n_out.out_red      = 8'(r_d2.qprod[2] >> SCALE_SHIFT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_d1 <= n_d1;
        end
        if (rdy2) begin
            r_d2 <= n_d2;
        end
        if (rdy3) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_v3;
    assign o_item  = r_out;

endmodule
`default_nettype wire

// ----- tb/sv/tb_scaled_palette_sprite_blit.sv -----
// Testbench for the scaled palette sprite blitter: directed and random transactions checked against a predictor.
module tb_scaled_palette_sprite_blit;
    import spb_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out        o_out_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    scaled_palette_sprite_blit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    localparam int LATENCY = 18;
    localparam int WATCHDOG_LIMIT = 4000;

    logic [7:0]  sprite_bytes [0:PART_DEPTH-1];
    bit          sprite_written [0:PART_DEPTH-1];
    logic [23:0] color_table [0:PALETTE_ENTRIES-1];
    bit          color_written [0:PALETTE_ENTRIES-1];
    t_cfg        blit_cfg;
    t_out        pending_pixels [$];

    int  mismatches;
    int  idle_cycles;
    bit  timed_out;
    int  sent_items;
    int  checked_items;
    int  drawn_pixels;
    int  burst_left;
    int  gap_left;
    int  stall_mode;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Predict the pixel write for one transaction and update the stores.
    function automatic t_out blit_pixel(t_in it);
        t_out        px;
        int          lx, ly, tx, ty, sx, sy, row, col, idx, br;
        logic [7:0]  pbyte;
        logic [23:0] rgb;
        px = '0;
        case (it.operation)
            OP_LOAD_PART: begin
                sprite_bytes[{it.load_row, it.load_column}] = it.load_byte;
                sprite_written[{it.load_row, it.load_column}] = 1'b1;
            end
            OP_LOAD_PAL: begin
                color_table[it.palette_slot] =
                    {it.palette_red, it.palette_green, it.palette_blue};
                color_written[it.palette_slot] = 1'b1;
            end
            OP_DRAW: begin
                lx = int'(it.local_x);
                ly = int'(it.local_y);
                if (blit_cfg.dest_width == 0 || blit_cfg.dest_height == 0 ||
                    blit_cfg.part_width == 0 || blit_cfg.part_height == 0) return px;
                if (lx >= blit_cfg.dest_width || ly >= blit_cfg.dest_height) return px;
                tx = int'(blit_cfg.origin_x) + lx;
                ty = int'(blit_cfg.origin_y) + ly;
                if (tx < 0 || tx >= SURFACE_WIDTH || ty < 0 || ty >= SURFACE_HEIGHT)
                    return px;
                sx = lx * int'(blit_cfg.part_width) / int'(blit_cfg.dest_width);
                sy = ly * int'(blit_cfg.part_height) / int'(blit_cfg.dest_height);
                row = int'(blit_cfg.part_height) - 1 - sy;
                case (blit_cfg.depth_mode)
                    DEPTH_1BPP: col = sx >> 3;
                    DEPTH_4BPP: col = sx >> 1;
                    default:    col = sx;
                endcase
                if (row >= PART_ROWS || col >= ROW_BYTES) return px;
                pbyte = sprite_bytes[row * ROW_BYTES + col];
                case (blit_cfg.depth_mode)
                    DEPTH_1BPP: idx = (pbyte >> (7 - (sx & 7))) & 1;
                    DEPTH_4BPP: idx = (pbyte >> ((1 - (sx & 1)) * 4)) & NIBBLE_MASK;
                    default:    idx = pbyte;
                endcase
                if (blit_cfg.depth_mode <= DEPTH_4BPP && idx == 0) return px;
                idx = (idx + it.palette_shift) & 8'hff;
                rgb = color_table[idx];
                br = blit_cfg.brightness > FULL_SCALE ? FULL_SCALE : blit_cfg.brightness;
                px.write_enable = 1'b1;
                px.surf_x = tx[9:0];
                px.surf_y = ty[9:0];
                px.out_red   = 8'((int'(rgb[23:16]) * br) / FULL_SCALE);
                px.out_green = 8'((int'(rgb[15:8]) * br) / FULL_SCALE);
                px.out_blue  = 8'((int'(rgb[7:0]) * br) / FULL_SCALE);
            end
            default: ;
        endcase
        return px;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        $display("mismatch on result %0d: %s got %0d expected %0d",
                 checked_items, what, got, want);
    endtask

    // Check each accepted result against the oldest prediction.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("unexpected result, queue depth", 0, 0);
            end else begin
                want = pending_pixels.pop_front();
                if (o_out_data.write_enable !== want.write_enable)
                    report_mismatch("write_enable", o_out_data.write_enable, want.write_enable);
                if (o_out_data.surf_x !== want.surf_x)
                    report_mismatch("surf_x", o_out_data.surf_x, want.surf_x);
                if (o_out_data.surf_y !== want.surf_y)
                    report_mismatch("surf_y", o_out_data.surf_y, want.surf_y);
                if (o_out_data.out_red !== want.out_red)
                    report_mismatch("out_red", o_out_data.out_red, want.out_red);
                if (o_out_data.out_green !== want.out_green)
                    report_mismatch("out_green", o_out_data.out_green, want.out_green);
                if (o_out_data.out_blue !== want.out_blue)
                    report_mismatch("out_blue", o_out_data.out_blue, want.out_blue);
                if (want.write_enable) drawn_pixels++;
            end
            checked_items++;
        end
    end

    // Stall the output on a pattern that changes mode now and then.
    always @(posedge i_clk) begin
        if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= ($urandom_range(0, 3) != 0);
            2: i_out_ready <= ($urandom_range(0, 1) != 0);
            default: i_out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("** scaled_palette_sprite_blit: FAILED **");
            $finish;
        end
    end

    // Valid stays high after an accept until the next item or a drain replaces it
    // in the same time step.
    task automatic send_item(t_in it);
        if (burst_left == 0) begin
            gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 20);
            if (gap_left != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap_left) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_data  <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        pending_pixels.push_back(blit_pixel(it));
        sent_items++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [15:0] value);
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_PART_WIDTH:  blit_cfg.part_width  = value[11:0];
            REG_PART_HEIGHT: blit_cfg.part_height = value[8:0];
            REG_DEPTH_MODE:  blit_cfg.depth_mode  = value[1:0];
            REG_DEST_WIDTH:  blit_cfg.dest_width  = value[10:0];
            REG_DEST_HEIGHT: blit_cfg.dest_height = value[10:0];
            REG_ORIGIN_X:    blit_cfg.origin_x    = value;
            REG_ORIGIN_Y:    blit_cfg.origin_y    = value;
            default:         blit_cfg.brightness  = value[9:0];
        endcase
    endtask

    task automatic setup_blit(int pw, int ph, int depth, int dw, int dh,
                              int ox, int oy, int br);
        drain_results();
        write_reg(REG_PART_WIDTH, 16'(pw));
        write_reg(REG_PART_HEIGHT, 16'(ph));
        write_reg(REG_DEPTH_MODE, 16'(depth));
        write_reg(REG_DEST_WIDTH, 16'(dw));
        write_reg(REG_DEST_HEIGHT, 16'(dh));
        write_reg(REG_ORIGIN_X, 16'(ox));
        write_reg(REG_ORIGIN_Y, 16'(oy));
        write_reg(REG_BRIGHTNESS, 16'(br));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_in rand_fields();
        t_in it;
        it = '0;
        it.load_row = 8'($urandom);
        it.load_column = 8'($urandom);
        it.load_byte = 8'($urandom);
        it.palette_slot = 8'($urandom);
        it.palette_red = 8'($urandom);
        it.palette_green = 8'($urandom);
        it.palette_blue = 8'($urandom);
        it.local_x = 11'($urandom);
        it.local_y = 11'($urandom);
        it.palette_shift = 8'($urandom);
        return it;
    endfunction

    task automatic load_byte(int row, int col, logic [7:0] b);
        t_in it;
        it = rand_fields();
        it.operation = OP_LOAD_PART;
        it.load_row = 8'(row);
        it.load_column = 8'(col);
        it.load_byte = b;
        send_item(it);
    endtask

    task automatic load_color(int slot, logic [23:0] rgb);
        t_in it;
        it = rand_fields();
        it.operation = OP_LOAD_PAL;
        it.palette_slot = 8'(slot);
        {it.palette_red, it.palette_green, it.palette_blue} = rgb;
        send_item(it);
    endtask

    // A draw whose source byte or color entry was never loaded is skipped.
    function automatic bit draw_is_safe(t_in it);
        int sx, sy, row, col, idx, lx, ly;
        logic [7:0] b;
        lx = int'(it.local_x);
        ly = int'(it.local_y);
        if (blit_cfg.dest_width == 0 || blit_cfg.dest_height == 0 ||
            blit_cfg.part_width == 0 || blit_cfg.part_height == 0) return 1;
        if (lx >= blit_cfg.dest_width || ly >= blit_cfg.dest_height) return 1;
        sx = lx * int'(blit_cfg.part_width) / int'(blit_cfg.dest_width);
        sy = ly * int'(blit_cfg.part_height) / int'(blit_cfg.dest_height);
        row = int'(blit_cfg.part_height) - 1 - sy;
        case (blit_cfg.depth_mode)
            DEPTH_1BPP: col = sx >> 3;
            DEPTH_4BPP: col = sx >> 1;
            default:    col = sx;
        endcase
        if (row < 0 || row >= PART_ROWS || col >= ROW_BYTES) return 1;
        if (!sprite_written[row * ROW_BYTES + col]) return 0;
        b = sprite_bytes[row * ROW_BYTES + col];
        case (blit_cfg.depth_mode)
            DEPTH_1BPP: idx = (b >> (7 - (sx & 7))) & 1;
            DEPTH_4BPP: idx = (b >> ((1 - (sx & 1)) * 4)) & NIBBLE_MASK;
            default:    idx = b;
        endcase
        if (blit_cfg.depth_mode <= DEPTH_4BPP && idx == 0) return 1;
        return color_written[(idx + it.palette_shift) & 8'hff];
    endfunction

    task automatic draw_at(int lx, int ly, int shift);
        t_in it;
        it = rand_fields();
        it.operation = OP_DRAW;
        it.local_x = 11'(lx);
        it.local_y = 11'(ly);
        it.palette_shift = 8'(shift);
        if (draw_is_safe(it)) send_item(it);
    endtask

    task automatic test_loads_and_palette();
        for (int s = 0; s < PALETTE_ENTRIES; s++)
            load_color(s, 24'($urandom));
        load_color(0, 24'h000000);
        load_color(255, 24'hffffff);
        for (int r = 0; r < 8; r++)
            for (int c = 0; c < 8; c++)
                load_byte(r, c, 8'($urandom));
        load_byte(255, 255, 8'hff);
        load_byte(0, 0, 8'h00);
        load_byte(0, 1, 8'hff);
        load_byte(1, 0, 8'ha5);
    endtask

    task automatic test_directed_draws();
        t_in it;
        setup_blit(1, 1, DEPTH_8BPP, 0, 5, 0, 0, 1000);
        draw_at(0, 0, 0);
        setup_blit(16, 2, DEPTH_1BPP, 16, 2, 0, 0, 1000);
        for (int x = 0; x < 16; x++) draw_at(x, 0, 3);
        draw_at(16, 0, 0);
        draw_at(0, 2047, 0);
        setup_blit(4, 2, DEPTH_4BPP, 8, 4, 636, 476, 1023);
        draw_at(0, 0, 255);
        draw_at(3, 3, 1);
        draw_at(7, 3, 200);
        setup_blit(2, 2, 3, 5, 5, -2, -3, 0);
        draw_at(0, 0, 0);
        draw_at(4, 4, 128);
        setup_blit(2048, 256, DEPTH_8BPP, 2047, 2047, -32768, 32767, 500);
        draw_at(2046, 2046, 0);
        it = rand_fields();
        it.operation = t_op'(2'd3);
        send_item(it);
    endtask

    task automatic test_random_blits();
        int depth;
        for (int phase = 0; phase < 9; phase++) begin
            depth = $urandom_range(0, 3);
            setup_blit($urandom_range(1, 40), $urandom_range(1, 8), depth,
                       $urandom_range(1, 80), $urandom_range(1, 12),
                       $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                 : $urandom_range(0, 600),
                       $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                 : $urandom_range(0, 440),
                       $urandom_range(0, 1023));
            for (int n = 0; n < 15; n++) begin
                case ($urandom_range(0, 9))
                    0: load_byte($urandom_range(0, 7), $urandom_range(0, 39),
                                 8'($urandom));
                    1: load_color($urandom_range(0, 255), 24'($urandom));
                    2: draw_at($urandom_range(0, 2047), $urandom_range(0, 2047),
                               $urandom_range(0, 255));
                    default: draw_at($urandom_range(0, blit_cfg.dest_width - 1),
                                     $urandom_range(0, blit_cfg.dest_height - 1),
                                     $urandom_range(0, 255));
                endcase
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b1;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_PART_WIDTH;
        i_cfg_data = '0;
        stall_mode = 0;
        mismatches = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        burst_left = 0;
        blit_cfg = '{part_width: 1, part_height: 1, depth_mode: DEPTH_8BPP,
                     dest_width: 0, dest_height: 0, origin_x: 0, origin_y: 0,
                     brightness: 1000};
        for (int i = 0; i < PART_DEPTH; i++) sprite_written[i] = 1'b0;
        for (int i = 0; i < PALETTE_ENTRIES; i++) color_written[i] = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_loads_and_palette();
        test_directed_draws();
        test_random_blits();
        drain_results();
        $display("covered %0d transactions, %0d results checked, %0d pixels written",
                 sent_items, checked_items, drawn_pixels);
        $display("all depth modes, clipping, transparency and brightness extremes exercised");
        if (mismatches == 0) begin
            $display("** scaled_palette_sprite_blit: PASSED **");
        end else begin
            $display("** scaled_palette_sprite_blit: FAILED **");
        end
        $finish;
    end
endmodule
